// File: rtl/nnta_pkg.sv
// shared constants, types and helpers for the track association block
package nnta_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int ID_BITS    = 16;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int STEP_W     = $clog2(MAX_TRACKS + 2);
    localparam int POS_W      = 16;
    localparam int SQ_W       = 2 * POS_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int OUT_ID_W   = 16;

    localparam logic [POS_W-1:0] THRESHOLD_RESET = 16'd100;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_EOF   = 1'b1;

    typedef enum logic [1:0] {
        KIND_ASSIGN = 2'd0,
        KIND_TRACK  = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EOF_FIND,
        S_EOF_LOAD
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        t_pos               pos;
    } t_slot;

    typedef struct packed {
        t_kind               kind;
        logic [OUT_ID_W-1:0] id;
        t_pos                pos;
        logic                is_new;
        logic                full;
        logic                last;
    } t_result;

    // low bits of a track id as reported on the output
    function automatic logic [OUT_ID_W-1:0] to_out_id(input logic [ID_BITS-1:0] id);
        logic [31:0] w;
        w = 32'(id);
        return w[OUT_ID_W-1:0];
    endfunction

endpackage

// File: rtl/nnta_slot_ram.sv
// slot memory holding track id and position, registered read
module nnta_slot_ram
    import nnta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot r_mem [MAX_TRACKS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nnta_dist.sv
// squared distance unit: registered per-axis squares, summed on the output
module nnta_dist
    import nnta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  t_pos              i_point,
    input  t_pos              i_slot,
    output logic [DIST_W-1:0] o_dist
);

    logic signed [POS_W:0]     dx, dy, dz;
    logic signed [2*POS_W+1:0] px, py, pz;
    logic [SQ_W-1:0]           r_sqx, r_sqy, r_sqz;

    always_comb begin
        dx = {i_slot.x[POS_W-1], i_slot.x} - {i_point.x[POS_W-1], i_point.x};
        dy = {i_slot.y[POS_W-1], i_slot.y} - {i_point.y[POS_W-1], i_point.y};
        dz = {i_slot.z[POS_W-1], i_slot.z} - {i_point.z[POS_W-1], i_point.z};
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // a square of a 17 bit difference fits in 32 unsigned bits
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sqx <= px[SQ_W-1:0];
            r_sqy <= py[SQ_W-1:0];
            r_sqz <= pz[SQ_W-1:0];
        end
    end

    assign o_dist = DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);

endmodule

// File: rtl/nearest_neighbour_track_association.sv
// nearest neighbour track association, one transaction in work at a time
// point: the MAX_TRACKS slots are read in turn through two pipeline stages (slot read, distance),
// then a commit step loads the result; the next transaction is accepted in the cycle after that
// end of frame: an empty report if no track is valid, else one report per valid track, each found
// and then loaded; next transaction in the cycle after the last report loads; out stalls delay these
// reset (synchronous, active low) clears all slots, the id counter and sets the threshold to 100
module nearest_neighbour_track_association
    import nnta_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [POS_W-1:0]        i_match_threshold_mm,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  logic signed [POS_W-1:0] i_point_x_mm,
    input  logic signed [POS_W-1:0] i_point_y_mm,
    input  logic signed [POS_W-1:0] i_point_z_mm,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_report_kind,
    output logic [OUT_ID_W-1:0]     o_track_id,
    output logic signed [POS_W-1:0] o_track_x_mm,
    output logic signed [POS_W-1:0] o_track_y_mm,
    output logic signed [POS_W-1:0] o_track_z_mm,
    output logic                    o_is_new_track,
    output logic                    o_table_full,
    output logic                    o_last
);

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_thr;
    logic [SQ_W-1:0]       r_limit;
    logic [MAX_TRACKS-1:0] r_valid, r_unm;
    logic [ID_BITS-1:0]    r_next_id;
    t_pos                  r_pt;
    logic [STEP_W-1:0]     r_step;
    logic                  r_s1_v;
    logic [IDX_W-1:0]      r_s1_idx;
    logic                  r_s2_v, r_s2_elig;
    logic [IDX_W-1:0]      r_s2_idx;
    logic [ID_BITS-1:0]    r_s2_id;
    logic                  r_best_v;
    logic [IDX_W-1:0]      r_best_idx;
    logic [ID_BITS-1:0]    r_best_id;
    logic [DIST_W-1:0]     r_best_d;
    logic [IDX_W-1:0]      r_ptr, r_cur;
    logic                  r_last;
    t_result               r_out;
    logic                  r_out_valid;

    logic              in_acc, out_free, issue, better;
    logic [DIST_W-1:0] cand_d;
    t_slot             ram_q, ram_wdata;
    logic              ram_re, ram_we;
    logic [IDX_W-1:0]  ram_raddr, ram_waddr;
    logic              out_load;
    t_result           out_next;
    logic [IDX_W-1:0]  found, hi, free_idx;
    logic              free_v;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign issue       = (r_state == S_SCAN) && (r_step < STEP_W'(MAX_TRACKS));

    nnta_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    nnta_dist u_dist (
        .i_clk   (i_clk),
        .i_load  (r_s1_v),
        .i_point (r_pt),
        .i_slot  (ram_q.pos),
        .o_dist  (cand_d)
    );

    // strict compare keeps the lower slot among equal distance and equal id
    assign better = r_s2_v && r_s2_elig && (cand_d < DIST_W'(r_limit)) &&
                    (!r_best_v || (cand_d < r_best_d) ||
                     ((cand_d == r_best_d) && (r_s2_id < r_best_id)));

    // slot searches over the valid bits
    always_comb begin
        found  = '0;
        hi     = '0;
        free_idx = '0;
        free_v = 1'b0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (r_valid[i] && (IDX_W'(i) >= r_ptr)) begin
                found = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
                free_v   = 1'b1;
            end
        end
        for (int i = 0; i < MAX_TRACKS; i++) begin
            if (r_valid[i]) begin
                hi = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_opcode == OP_EOF) ? S_EOF_FIND : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step == STEP_W'(MAX_TRACKS + 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EOF_FIND: begin
                if (r_valid == '0) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_EOF_LOAD;
                end
            end
            S_EOF_LOAD: begin
                if (out_free) begin
                    n_state = r_last ? S_IDLE : S_EOF_FIND;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and result control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_step[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = '{id: r_best_id, pos: r_pt};
        out_load  = 1'b0;
        out_next  = '{kind: KIND_ASSIGN, id: '0, pos: '0, is_new: 1'b0, full: 1'b0,
                      last: 1'b1};
        unique case (r_state)
            S_SCAN: begin
                ram_re = issue;
            end
            S_DECIDE: begin
                out_load = out_free;
                if (r_best_v) begin
                    ram_we      = out_free;
                    out_next.id  = to_out_id(r_best_id);
                    out_next.pos = r_pt;
                end else if (free_v) begin
                    ram_we          = out_free;
                    ram_waddr       = free_idx;
                    ram_wdata       = '{id: r_next_id, pos: r_pt};
                    out_next.id     = to_out_id(r_next_id);
                    out_next.pos    = r_pt;
                    out_next.is_new = 1'b1;
                end else begin
                    out_next.full = 1'b1;
                end
            end
            S_EOF_FIND: begin
                if (r_valid == '0) begin
                    out_load      = out_free;
                    out_next.kind = KIND_EMPTY;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = found;
                end
            end
            S_EOF_LOAD: begin
                out_load      = out_free;
                out_next.kind = KIND_TRACK;
                out_next.id   = to_out_id(ram_q.id);
                out_next.pos  = ram_q.pos;
                out_next.last = r_last;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THRESHOLD_RESET;
            r_valid     <= '0;
            r_unm       <= '0;
            r_next_id   <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_best_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_match_threshold_mm;
            end
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (in_acc) begin
                r_best_v <= 1'b0;
                // drop unmatched tracks, survivors become candidates again
                if (i_opcode == OP_EOF) begin
                    r_valid <= r_valid & ~r_unm;
                    r_unm   <= r_valid & ~r_unm;
                end
            end else if (better) begin
                r_best_v <= 1'b1;
            end
            if ((r_state == S_DECIDE) && out_free) begin
                if (r_best_v) begin
                    r_unm[r_best_idx] <= 1'b0;
                end else if (free_v) begin
                    r_valid[free_idx] <= 1'b1;
                    r_unm[free_idx]   <= 1'b0;
                    r_next_id         <= r_next_id + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pt    <= '{x: i_point_x_mm, y: i_point_y_mm, z: i_point_z_mm};
            r_step  <= '0;
            r_ptr   <= '0;
            r_limit <= r_thr * r_thr;
        end else if (r_state == S_SCAN) begin
            r_step <= r_step + 1'b1;
        end
        r_s1_idx  <= r_step[IDX_W-1:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_id   <= ram_q.id;
        r_s2_elig <= r_valid[r_s1_idx] & r_unm[r_s1_idx];
        if (better) begin
            r_best_idx <= r_s2_idx;
            r_best_id  <= r_s2_id;
            r_best_d   <= cand_d;
        end
        if ((r_state == S_EOF_FIND) && (r_valid != '0)) begin
            r_cur  <= found;
            r_last <= (found == hi);
        end
        if ((r_state == S_EOF_LOAD) && out_free) begin
            r_ptr <= r_cur + 1'b1;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_report_kind  = r_out.kind;
    assign o_track_id     = r_out.id;
    assign o_track_x_mm   = r_out.pos.x;
    assign o_track_y_mm   = r_out.pos.y;
    assign o_track_z_mm   = r_out.pos.z;
    assign o_is_new_track = r_out.is_new;
    assign o_table_full   = r_out.full;
    assign o_last         = r_out.last;

endmodule
